@@ design/q16a_pkg.sv @@
// ----------------------------------------------------------------------------
// q16a_pkg
// Shared types and constants for the signed Q16.16 arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package q16a_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned CmdW  = 3;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [DataW-1:0] OVF_CODE = 32'h8000_0000;

	// Reset values of the configuration registers.
	localparam logic              RST_ROUNDING = 1'b1;
	localparam logic              RST_SATURATE = 1'b0;
	localparam logic [DataW-1:0]  RST_MIN_LIMIT = 32'h8000_0001;
	localparam logic [DataW-1:0]  RST_MAX_LIMIT = 32'h7FFF_FFFF;

	// Command codes.
	localparam logic [CmdW-1:0] CMD_ADD  = 3'd0;
	localparam logic [CmdW-1:0] CMD_SUB  = 3'd1;
	localparam logic [CmdW-1:0] CMD_MUL  = 3'd2;
	localparam logic [CmdW-1:0] CMD_DIV  = 3'd3;
	localparam logic [CmdW-1:0] CMD_SQRT = 3'd4;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_ROUNDING  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SATURATE  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_LIMIT = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_LIMIT = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_SUB,
		ST_MUL,
		ST_MULR,
		ST_DNORM,
		ST_DTOP,
		ST_DLOOP,
		ST_SSHR,
		ST_SLOOP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             rounding_on;
		logic             saturate_on;
		logic [DataW-1:0] min_limit;
		logic [DataW-1:0] max_limit;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [DataW-1:0] result;
		logic             overflowed;
	} core_res_t;

endpackage

`default_nettype wire

@@ design/q16a_if.sv @@
// ----------------------------------------------------------------------------
// q16a_in_if / q16a_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface q16a_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source (output valid, command, operand_a, operand_b, input ready);
	modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface q16a_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] result;
	logic        overflowed;

	modport source (output valid, result, overflowed, input ready);
	modport sink   (input valid, result, overflowed, output ready);
endinterface

`default_nettype wire

@@ design/q16a_core.sv @@
// ----------------------------------------------------------------------------
// q16a_core
// Sequencer and datapath: one shared 32-bit subtract/compare unit steps the
// divide and square root one bit per cycle; add, subtract and multiply pass
// through a few fixed states.
// ----------------------------------------------------------------------------
`default_nettype none

module q16a_core (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  start,
	input  wire  logic [2:0]            cmd,
	input  wire  logic [31:0]           op_a,
	input  wire  logic [31:0]           op_b,
	input  wire  q16a_pkg::cfg_t        cfg,
	input  wire  logic                  take,
	output logic                        idle,
	output q16a_pkg::core_res_t         res
);

	q16a_pkg::state_t state_q, state_d;

	logic [31:0] a_q, a_d, b_q, b_d;
	logic [31:0] acc_q, acc_d;      // remainder or radicand
	logic [31:0] dv_q, dv_d;        // divisor or root
	logic [31:0] bit_q, bit_d;
	logic [31:0] quo_q, quo_d;
	logic [31:0] r_q, r_d;
	logic        pass_q, pass_d;
	logic        sat_en_q, sat_en_d;
	logic        to_max_q, to_max_d;
	logic        vld_q, vld_d;
	logic [63:0] prod_s1, prod_d;
	logic signed [63:0] mul_p;

	// Shared subtract/compare unit.
	logic [31:0] sub_x, sub_y;
	logic [32:0] diff;
	logic        ge;

	logic [31:0] sum, dif, u_rnd, fin, mid_num, rb;
	logic        neg_q;

	assign diff = {1'b0, sub_x} - {1'b0, sub_y};
	assign ge   = !diff[32];
	assign rb   = dv_q + bit_q;
	assign neg_q = a_q[31] ^ b_q[31];

	// Operand selection for the shared unit.
	always_comb begin
		sub_x = acc_q;
		sub_y = dv_q;
		case (state_q)
			q16a_pkg::ST_SSHR: begin
				sub_y = bit_q;
			end
			q16a_pkg::ST_SLOOP: begin
				if (bit_q != 32'd0) begin
					sub_y = rb;
				end else begin
					sub_x = dv_q;
					sub_y = acc_q;
				end
			end
			default: begin
				sub_x = acc_q;
				sub_y = dv_q;
			end
		endcase
	end

	assign sum     = a_q + b_q;
	assign dif     = a_q - b_q;
	assign u_rnd   = 32'(prod_s1[47:0] - 48'h8000 - {47'd0, prod_s1[63]} >> 16);
	assign mid_num = 32'((acc_q - dv_q) << 16) - 32'd32768;

	// Signed 32 by 32 product, full 64-bit width.
	assign mul_p = $signed(a_q) * $signed(b_q);

	// Saturation of the finished value.
	always_comb begin
		fin = r_q;
		if (sat_en_q && cfg.saturate_on && r_q == q16a_pkg::OVF_CODE) begin
			fin = to_max_q ? cfg.max_limit : cfg.min_limit;
		end
	end

	assign idle           = (state_q == q16a_pkg::ST_IDLE);
	assign res.done       = (state_q == q16a_pkg::ST_FIN);
	assign res.result     = fin;
	assign res.overflowed = vld_q && (fin == q16a_pkg::OVF_CODE);

	// Next state and datapath updates.
	always_comb begin
		state_d  = state_q;
		a_d      = a_q;
		b_d      = b_q;
		acc_d    = acc_q;
		dv_d     = dv_q;
		bit_d    = bit_q;
		quo_d    = quo_q;
		r_d      = r_q;
		pass_d   = pass_q;
		sat_en_d = sat_en_q;
		to_max_d = to_max_q;
		vld_d    = vld_q;
		prod_d   = prod_s1;
		case (state_q)
			q16a_pkg::ST_IDLE: begin
				if (start) begin
					a_d      = op_a;
					b_d      = op_b;
					acc_d    = op_a[31] ? 32'd0 - op_a : op_a;
					dv_d     = op_b[31] ? 32'd0 - op_b : op_b;
					bit_d    = 32'h0001_0000;
					quo_d    = 32'd0;
					pass_d   = 1'b0;
					vld_d    = 1'b1;
					sat_en_d = 1'b1;
					to_max_d = !(op_a[31] ^ op_b[31]);
					r_d      = 32'd0;
					case (cmd)
						q16a_pkg::CMD_ADD: begin
							to_max_d = !op_a[31];
							state_d  = q16a_pkg::ST_ADD;
						end
						q16a_pkg::CMD_SUB: begin
							to_max_d = !op_a[31];
							state_d  = q16a_pkg::ST_SUB;
						end
						q16a_pkg::CMD_MUL: begin
							state_d = q16a_pkg::ST_MUL;
						end
						q16a_pkg::CMD_DIV: begin
							state_d = q16a_pkg::ST_DNORM;
						end
						q16a_pkg::CMD_SQRT: begin
							sat_en_d = 1'b0;
							acc_d    = op_a;
							dv_d     = 32'd0;
							bit_d    = (op_a[31:20] != 12'd0) ? 32'h4000_0000 : 32'h0004_0000;
							if (op_a == 32'd0 || op_a[31]) begin
								r_d     = q16a_pkg::OVF_CODE;
								state_d = q16a_pkg::ST_FIN;
							end else begin
								state_d = q16a_pkg::ST_SSHR;
							end
						end
						default: begin
							vld_d    = 1'b0;
							sat_en_d = 1'b0;
							state_d  = q16a_pkg::ST_FIN;
						end
					endcase
				end
			end
			q16a_pkg::ST_ADD: begin
				r_d = (!(a_q[31] ^ b_q[31]) && (a_q[31] ^ sum[31])) ? q16a_pkg::OVF_CODE : sum;
				state_d = q16a_pkg::ST_FIN;
			end
			q16a_pkg::ST_SUB: begin
				r_d = ((a_q[31] ^ b_q[31]) && (a_q[31] ^ dif[31])) ? q16a_pkg::OVF_CODE : dif;
				state_d = q16a_pkg::ST_FIN;
			end
			q16a_pkg::ST_MUL: begin
				prod_d  = mul_p;
				state_d = q16a_pkg::ST_MULR;
			end
			q16a_pkg::ST_MULR: begin
				// The product fits when bits 63 down to 47 all agree.
				if (prod_s1[63:47] == {17{prod_s1[47]}}) begin
					r_d = cfg.rounding_on ? u_rnd + 32'd1 : prod_s1[47:16];
				end else begin
					r_d = q16a_pkg::OVF_CODE;
				end
				state_d = q16a_pkg::ST_FIN;
			end
			q16a_pkg::ST_DNORM: begin
				// Scale the divisor up until it reaches the remainder; a zero divisor or too large a quotient ends early.
				if (b_q == 32'd0) begin
					r_d     = cfg.min_limit;
					state_d = q16a_pkg::ST_FIN;
				end else if (ge && diff[31:0] != 32'd0) begin
					dv_d  = dv_q << 1;
					bit_d = bit_q << 1;
				end else if (bit_q == 32'd0) begin
					r_d     = q16a_pkg::OVF_CODE;
					state_d = q16a_pkg::ST_FIN;
				end else begin
					state_d = q16a_pkg::ST_DTOP;
				end
			end
			q16a_pkg::ST_DTOP: begin
				if (dv_q[31]) begin
					if (ge) begin
						quo_d = quo_q | bit_q;
						acc_d = diff[31:0];
					end
					dv_d  = dv_q >> 1;
					bit_d = bit_q >> 1;
				end
				state_d = q16a_pkg::ST_DLOOP;
			end
			q16a_pkg::ST_DLOOP: begin
				// One quotient bit per cycle.
				if (bit_q != 32'd0 && acc_q != 32'd0) begin
					if (ge) begin
						quo_d = quo_q | bit_q;
						acc_d = diff[31:0] << 1;
					end else begin
						acc_d = acc_q << 1;
					end
					bit_d = bit_q >> 1;
				end else begin
					quo_d = quo_q + {31'd0, cfg.rounding_on && ge};
					r_d   = neg_q ? 32'd0 - quo_d : quo_d;
					state_d = q16a_pkg::ST_FIN;
				end
			end
			q16a_pkg::ST_SSHR: begin
				if (!ge) begin
					bit_d = bit_q >> 2;
				end else begin
					state_d = q16a_pkg::ST_SLOOP;
				end
			end
			q16a_pkg::ST_SLOOP: begin
				// One root bit per cycle; between the passes the radicand is scaled up.
				if (bit_q != 32'd0) begin
					if (ge) begin
						acc_d = diff[31:0];
						dv_d  = (dv_q >> 1) + bit_q;
					end else begin
						dv_d = dv_q >> 1;
					end
					bit_d = bit_q >> 2;
				end else if (!pass_q) begin
					if (acc_q > 32'd65535) begin
						acc_d = mid_num;
						dv_d  = (dv_q << 16) + 32'd32768;
					end else begin
						acc_d = acc_q << 16;
						dv_d  = dv_q << 16;
					end
					bit_d  = 32'h0000_4000;
					pass_d = 1'b1;
				end else begin
					r_d     = dv_q + {31'd0, cfg.rounding_on && !ge};
					state_d = q16a_pkg::ST_FIN;
				end
			end
			q16a_pkg::ST_FIN: begin
				if (take) begin
					state_d = q16a_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = q16a_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= q16a_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		a_q      <= a_d;
		b_q      <= b_d;
		acc_q    <= acc_d;
		dv_q     <= dv_d;
		bit_q    <= bit_d;
		quo_q    <= quo_d;
		r_q      <= r_d;
		pass_q   <= pass_d;
		sat_en_q <= sat_en_d;
		to_max_q <= to_max_d;
		vld_q    <= vld_d;
		prod_s1  <= prod_d;
	end

endmodule

`default_nettype wire

@@ design/q16_16_arith_unit.sv @@
// ----------------------------------------------------------------------------
// Add and subtract finish through ST_ADD or ST_SUB, multiply through ST_MUL and ST_MULR,
// and divide and square root through the one-bit-per-cycle loops of the shared
// subtract/compare unit. One item at a time is in the core; the core is ready for
// the next item once its result has entered the output register.
// Reset clears the sequencer and output valid and loads the register defaults.
// ----------------------------------------------------------------------------
// q16_16_arith_unit
// Signed Q16.16 arithmetic unit with configuration registers and an output
// register that frees the core while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module q16_16_arith_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	q16a_in_if.sink                            in_ch,
	q16a_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [q16a_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [q16a_pkg::DataW-1:0]    cfg_data
);

	q16a_pkg::cfg_t      cfg_q;
	q16a_pkg::core_res_t core_res;
	logic                core_idle;
	logic                take;
	logic                out_valid_q;
	logic [31:0]         result_q;
	logic                ovf_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rounding_on <= q16a_pkg::RST_ROUNDING;
			cfg_q.saturate_on <= q16a_pkg::RST_SATURATE;
			cfg_q.min_limit   <= q16a_pkg::RST_MIN_LIMIT;
			cfg_q.max_limit   <= q16a_pkg::RST_MAX_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				q16a_pkg::REG_ROUNDING:  cfg_q.rounding_on <= cfg_data[0];
				q16a_pkg::REG_SATURATE:  cfg_q.saturate_on <= cfg_data[0];
				q16a_pkg::REG_MIN_LIMIT: cfg_q.min_limit   <= cfg_data;
				q16a_pkg::REG_MAX_LIMIT: cfg_q.max_limit   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready = core_idle;

	q16a_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_ch.valid),
		.cmd    (in_ch.command),
		.op_a   (in_ch.operand_a),
		.op_b   (in_ch.operand_b),
		.cfg    (cfg_q),
		.take   (take),
		.idle   (core_idle),
		.res    (core_res)
	);

	// Output register: loads a finished item when empty or being drained.
	assign take = core_res.done && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= core_res.result;
			ovf_q    <= core_res.overflowed;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.result     = result_q;
	assign out_ch.overflowed = ovf_q;

	// An accepted item keeps the core busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("core ready right after accepting an item");

	// A finished item with an empty output register shows up next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		core_res.done && !out_valid_q |=> out_ch.valid)
		else $error("finished item not loaded into output register");

	// The overflow flag only marks the overflow code.
	a_ovf_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.overflowed |-> out_ch.result == q16a_pkg::OVF_CODE)
		else $error("overflow flag set on a value other than the overflow code");

endmodule

`default_nettype wire
